// ===== src/acpu_pkg.sv =====
// Package with the word sizes, operation codes, status codes and shared types of the execute stage.
package acpu_pkg;

   // Datapath sizes.
   localparam int WORD_WIDTH = 20;
   localparam int ADDR_WIDTH = 12;
   localparam int OPC_WIDTH  = 6;
   localparam int MODE_WIDTH = 2;

   // Addressing mode that load immediate requires.
   localparam logic [MODE_WIDTH-1:0] MODE_DIRECT = '0;

   // Operation codes carried in bits 5..1 of the opcode field.
   typedef enum logic [4:0] {
      OP_HALT = 5'b00000,
      OP_NOP  = 5'b00001,
      OP_LD   = 5'b01000,
      OP_ST   = 5'b01001,
      OP_EM   = 5'b01010,
      OP_LI   = 5'b01011,
      OP_LDXR = 5'b01100,
      OP_LIXR = 5'b01101,
      OP_STXR = 5'b01110,
      OP_ADD  = 5'b10000,
      OP_SUB  = 5'b10001,
      OP_CLR  = 5'b10010,
      OP_COM  = 5'b10011,
      OP_AND  = 5'b10100,
      OP_OR   = 5'b10101,
      OP_XOR  = 5'b10110,
      OP_TR   = 5'b11000,
      OP_TZ   = 5'b11001,
      OP_TN   = 5'b11010,
      OP_TP   = 5'b11011
   } op_type;

   // Completion status of one instruction.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_HALT  = 2'd1,
      ST_UNDEF = 2'd2,
      ST_MODE  = 2'd3
   } status_type;

   // Architectural state of the machine.
   typedef struct packed {
      logic [WORD_WIDTH-1:0] acc_a;
      logic [WORD_WIDTH-1:0] acc_b;
      logic [ADDR_WIDTH-1:0] index;
   } arch_state_type;

   // Everything one instruction produces.
   typedef struct packed {
      status_type            status;
      logic                  mem_write;
      logic [WORD_WIDTH-1:0] write_data;
      logic                  jump_taken;
      logic [ADDR_WIDTH-1:0] jump_target;
      arch_state_type        next_state;
   } exec_result_type;

endpackage

// ===== src/acpu_exec.sv =====
// Combinational execute logic: decodes one instruction and computes its effects.
module acpu_exec
   import acpu_pkg::*;
(
   input  logic [OPC_WIDTH-1:0]  opcode_field,
   input  logic [MODE_WIDTH-1:0] addr_mode,
   input  logic [ADDR_WIDTH-1:0] address,
   input  logic [WORD_WIDTH-1:0] mem_data,
   input  arch_state_type        cur_state,
   output exec_result_type       result
);

   logic                  sel;
   op_type                op;
   logic [WORD_WIDTH-1:0] cur;
   logic [WORD_WIDTH-1:0] nreg;
   logic [ADDR_WIDTH-1:0] nxr;
   status_type            status;
   logic                  wr;
   logic [WORD_WIDTH-1:0] wdata;
   logic                  jmp;
   logic                  cur_neg;
   logic                  cur_zero;

   assign sel      = opcode_field[0];
   assign op       = op_type'(opcode_field[OPC_WIDTH-1:1]);
   assign cur      = sel ? cur_state.acc_b : cur_state.acc_a;
   assign cur_neg  = cur[WORD_WIDTH-1];
   assign cur_zero = (cur == '0);

   // Decode and compute the new register value, store and branch.
   always_comb begin
      nreg   = cur;
      nxr    = cur_state.index;
      status = ST_OK;
      wr     = 1'b0;
      wdata  = '0;
      jmp    = 1'b0;
      unique case (op)
         OP_HALT: begin
            status = sel ? ST_UNDEF : ST_HALT;
         end
         OP_NOP: begin
            if (sel) status = ST_UNDEF;
         end
         OP_LD: begin
            nreg = mem_data;
         end
         OP_ST: begin
            wr    = 1'b1;
            wdata = cur;
         end
         OP_EM: begin
            wr    = 1'b1;
            wdata = cur;
            nreg  = mem_data;
         end
         OP_LI: begin
            if (addr_mode != MODE_DIRECT) status = ST_MODE;
            else nreg = WORD_WIDTH'($signed(address));
         end
         OP_LDXR: begin
            if (sel) status = ST_UNDEF;
            else nxr = ADDR_WIDTH'(mem_data);
         end
         OP_LIXR: begin
            if (sel) status = ST_UNDEF;
            else nxr = address;
         end
         OP_STXR: begin
            if (sel) begin
               status = ST_UNDEF;
            end else begin
               wr    = 1'b1;
               wdata = WORD_WIDTH'(cur_state.index);
            end
         end
         OP_ADD: nreg = cur + mem_data;
         OP_SUB: nreg = cur - mem_data;
         OP_CLR: nreg = '0;
         OP_COM: nreg = ~cur;
         OP_AND: nreg = cur & mem_data;
         OP_OR:  nreg = cur | mem_data;
         OP_XOR: nreg = cur ^ mem_data;
         OP_TR: begin
            if (sel) status = ST_UNDEF;
            else jmp = 1'b1;
         end
         OP_TZ: jmp = cur_zero;
         OP_TN: jmp = cur_neg;
         OP_TP: jmp = !cur_neg && !cur_zero;
         default: status = ST_UNDEF;
      endcase
   end

   // A bad status suppresses every effect and leaves the state as it was.
   always_comb begin
      result.status     = status;
      result.next_state = cur_state;
      if (status == ST_OK) begin
         result.mem_write   = wr;
         result.write_data  = wdata;
         result.jump_taken  = jmp;
         result.jump_target = jmp ? address : '0;
         if (sel) result.next_state.acc_b = nreg;
         else result.next_state.acc_a = nreg;
         result.next_state.index = nxr;
      end else begin
         result.mem_write   = 1'b0;
         result.write_data  = '0;
         result.jump_taken  = 1'b0;
         result.jump_target = '0;
      end
   end

endmodule

// ===== src/acpu_regfile.sv =====
// Architectural registers A, B and XR, loaded when an instruction retires.
module acpu_regfile
   import acpu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           retire,
   input  arch_state_type next_state,
   output arch_state_type state
);

   arch_state_type state_ff;
   arch_state_type state_in;

   // Hold the state unless an instruction retires this cycle.
   always_comb begin
      state_in = retire ? next_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== src/accumulator_cpu_execute_stage_top.sv =====
// Top level of the execute stage: input register, execute logic, state and result register.
//
// The req_ channel carries one instruction per beat: opcode, addressing mode,
// effective address and the memory word read there. The rsp_ channel returns
// one result beat per instruction, in order: status, memory store, branch and
// the values of A, B and XR after the instruction.
// An accepted beat lands in the input register; once the result register is empty
// or being emptied, the execute logic works on it against A, B and XR and writes the
// result register and the architectural state at the same edge. A request beat thus
// passes through the input register and then the result register before its result
// is offered. The stage takes one instruction per cycle while rsp_ready stays high,
// since each one reads the state its predecessor wrote.
// When the receiver holds rsp_ready low, the result stays put, the input
// register keeps its beat and req_ready falls once both are full; nothing is
// lost or repeated.
// A synchronous active-high reset clears A, B and XR to zero and empties
// both registers.
module accumulator_cpu_execute_stage_top
   import acpu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OPC_WIDTH-1:0]  req_opcode_field,
   input  logic [MODE_WIDTH-1:0] req_addr_mode,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  logic [WORD_WIDTH-1:0] req_mem_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_mem_write,
   output logic [WORD_WIDTH-1:0] rsp_write_data,
   output logic                  rsp_jump_taken,
   output logic [ADDR_WIDTH-1:0] rsp_jump_target,
   output logic [WORD_WIDTH-1:0] rsp_acc_a_value,
   output logic [WORD_WIDTH-1:0] rsp_acc_b_value,
   output logic [ADDR_WIDTH-1:0] rsp_index_value
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [OPC_WIDTH-1:0]  in_opcode_ff;
   logic [MODE_WIDTH-1:0] in_mode_ff;
   logic [ADDR_WIDTH-1:0] in_address_ff;
   logic [WORD_WIDTH-1:0] in_mem_data_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   exec_result_type       out_ff;
   exec_result_type       exec_res;
   arch_state_type        cur_state;
   logic                  advance;
   logic                  req_take;

   // Handshake: the instruction in the input register moves on whenever the
   // result register is empty or is being emptied this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff   <= req_opcode_field;
         in_mode_ff     <= req_addr_mode;
         in_address_ff  <= req_address;
         in_mem_data_ff <= req_mem_data;
      end
   end

   acpu_exec u_exec (
      .opcode_field (in_opcode_ff),
      .addr_mode    (in_mode_ff),
      .address      (in_address_ff),
      .mem_data     (in_mem_data_ff),
      .cur_state    (cur_state),
      .result       (exec_res)
   );

   acpu_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .retire     (advance),
      .next_state (exec_res.next_state),
      .state      (cur_state)
   );

   // Result payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= exec_res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_mem_write   = out_ff.mem_write;
   assign rsp_write_data  = out_ff.write_data;
   assign rsp_jump_taken  = out_ff.jump_taken;
   assign rsp_jump_target = out_ff.jump_target;
   assign rsp_acc_a_value = out_ff.next_state.acc_a;
   assign rsp_acc_b_value = out_ff.next_state.acc_b;
   assign rsp_index_value = out_ff.next_state.index;

`ifndef SYNTHESIS
   // A faulting or halting instruction leaves A, B and XR untouched.
   a_bad_status_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && (exec_res.status != ST_OK) |=> $stable(cur_state))
      else $error("state changed on a bad status");

   // A bad status carries no store and no branch.
   a_bad_status_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         !rsp_mem_write && !rsp_jump_taken && (rsp_write_data == '0))
      else $error("store or branch reported with a bad status");

   // The result shows the state that the retiring instruction left behind.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_acc_a_value == cur_state.acc_a) &&
                  (rsp_acc_b_value == cur_state.acc_b) &&
                  (rsp_index_value == cur_state.index))
      else $error("result register disagrees with the state");

   // An untaken branch reports a zero target.
   a_no_jump_zero_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_jump_taken |-> (rsp_jump_target == '0))
      else $error("jump target set without a jump");
`endif

endmodule

// ===== tb/sv/accumulator_cpu_execute_stage_top_tb.sv =====
// Self-checking testbench for the accumulator CPU execute stage, with random handshake pressure.
module accumulator_cpu_execute_stage_top_tb
   import acpu_pkg::*;
;

   localparam int  RANDOM_ITEMS = 2000;
   localparam int  LIMIT_CYCLES = 300000;
   localparam int  DRAIN_CYCLES = 8;
   localparam int  CALM_TAIL    = 200;
   localparam logic SEL_A       = 1'b0;
   localparam logic SEL_B       = 1'b1;
   // Operation code that the machine does not define.
   localparam logic [4:0] OP_UNLISTED = 5'b11111;

   // One instruction beat waiting to be driven.
   typedef struct {
      logic [OPC_WIDTH-1:0]  opcode;
      logic [MODE_WIDTH-1:0] mode;
      logic [ADDR_WIDTH-1:0] address;
      logic [WORD_WIDTH-1:0] mem_data;
   } instr_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OPC_WIDTH-1:0]  req_opcode_field = '0;
   logic [MODE_WIDTH-1:0] req_addr_mode = '0;
   logic [ADDR_WIDTH-1:0] req_address = '0;
   logic [WORD_WIDTH-1:0] req_mem_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic                  rsp_mem_write;
   logic [WORD_WIDTH-1:0] rsp_write_data;
   logic                  rsp_jump_taken;
   logic [ADDR_WIDTH-1:0] rsp_jump_target;
   logic [WORD_WIDTH-1:0] rsp_acc_a_value;
   logic [WORD_WIDTH-1:0] rsp_acc_b_value;
   logic [ADDR_WIDTH-1:0] rsp_index_value;

   instr_beat_type  instr_queue[$];
   exec_result_type predicted_retires[$];
   op_type          legal_ops[$];
   arch_state_type  arch = '0;
   instr_beat_type  next_beat;
   exec_result_type retire_exp;
   int              errors = 0;
   int              beats_sent = 0;
   int              cycle_count = 0;
   int              gap_left = 0;
   int              stall_left = 0;

   accumulator_cpu_execute_stage_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode_field(req_opcode_field),
      .req_addr_mode   (req_addr_mode),
      .req_address     (req_address),
      .req_mem_data    (req_mem_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_mem_write   (rsp_mem_write),
      .rsp_write_data  (rsp_write_data),
      .rsp_jump_taken  (rsp_jump_taken),
      .rsp_jump_target (rsp_jump_target),
      .rsp_acc_a_value (rsp_acc_a_value),
      .rsp_acc_b_value (rsp_acc_b_value),
      .rsp_index_value (rsp_index_value)
   );

   always #2 clock = ~clock;

   // Executes one instruction against the shadow A, B and XR and returns what it retires.
   function automatic exec_result_type execute_instr(
      input logic [OPC_WIDTH-1:0]  opc,
      input logic [MODE_WIDTH-1:0] mode,
      input logic [ADDR_WIDTH-1:0] addr,
      input logic [WORD_WIDTH-1:0] mem
   );
      op_type                op;
      logic                  sel;
      logic [WORD_WIDTH-1:0] cur;
      logic [WORD_WIDTH-1:0] nreg;
      logic [ADDR_WIDTH-1:0] nxr;
      exec_result_type       r;
      sel  = opc[0];
      op   = op_type'(opc[OPC_WIDTH-1:1]);
      cur  = sel ? arch.acc_b : arch.acc_a;
      nreg = cur;
      nxr  = arch.index;
      r    = '0;
      r.status = ST_OK;
      case (op)
         OP_HALT: r.status = sel ? ST_UNDEF : ST_HALT;
         OP_NOP: if (sel) r.status = ST_UNDEF;
         OP_LD: nreg = mem;
         OP_ST: begin
            r.mem_write  = 1'b1;
            r.write_data = cur;
         end
         OP_EM: begin
            r.mem_write  = 1'b1;
            r.write_data = cur;
            nreg         = mem;
         end
         OP_LI: begin
            if (mode != MODE_DIRECT) r.status = ST_MODE;
            else nreg = {{(WORD_WIDTH-ADDR_WIDTH){addr[ADDR_WIDTH-1]}}, addr};
         end
         OP_LDXR: if (sel) r.status = ST_UNDEF; else nxr = mem[ADDR_WIDTH-1:0];
         OP_LIXR: if (sel) r.status = ST_UNDEF; else nxr = addr;
         OP_STXR: begin
            if (sel) begin
               r.status = ST_UNDEF;
            end else begin
               r.mem_write  = 1'b1;
               r.write_data = WORD_WIDTH'(arch.index);
            end
         end
         OP_ADD: nreg = cur + mem;
         OP_SUB: nreg = cur - mem;
         OP_CLR: nreg = '0;
         OP_COM: nreg = ~cur;
         OP_AND: nreg = cur & mem;
         OP_OR:  nreg = cur | mem;
         OP_XOR: nreg = cur ^ mem;
         OP_TR: if (sel) r.status = ST_UNDEF; else r.jump_taken = 1'b1;
         OP_TZ: r.jump_taken = (cur == '0);
         OP_TN: r.jump_taken = cur[WORD_WIDTH-1];
         OP_TP: r.jump_taken = !cur[WORD_WIDTH-1] && (cur != '0);
         default: r.status = ST_UNDEF;
      endcase
      // A bad status suppresses every side effect.
      if (r.status != ST_OK) begin
         r.mem_write  = 1'b0;
         r.write_data = '0;
         r.jump_taken = 1'b0;
      end else begin
         if (sel) arch.acc_b = nreg;
         else arch.acc_a = nreg;
         arch.index = nxr;
      end
      r.jump_target = r.jump_taken ? addr : '0;
      r.next_state  = arch;
      return r;
   endfunction

   task automatic queue_instr(
      input logic [OPC_WIDTH-1:0]  opc,
      input logic [MODE_WIDTH-1:0] mode,
      input logic [ADDR_WIDTH-1:0] addr,
      input logic [WORD_WIDTH-1:0] mem
   );
      instr_beat_type b;
      b.opcode   = opc;
      b.mode     = mode;
      b.address  = addr;
      b.mem_data = mem;
      instr_queue.push_back(b);
   endtask

   task automatic check_field(
      input string                 field,
      input logic [WORD_WIDTH-1:0] want,
      input logic [WORD_WIDTH-1:0] got
   );
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   // Idling is allowed outside the quiet stretches and stops near the end of the run.
   function automatic bit idle_window();
      return instr_queue.size() >= CALM_TAIL && ((beats_sent / 300) % 3 != 2);
   endfunction

   // Driver: predicts each accepted beat and offers the next one, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_retires.push_back(execute_instr(req_opcode_field, req_addr_mode,
                                                      req_address, req_mem_data));
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_window() && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 7) - 1;
               req_valid <= 1'b0;
            end else if (instr_queue.size() > 0) begin
               next_beat = instr_queue.pop_front();
               req_opcode_field <= next_beat.opcode;
               req_addr_mode    <= next_beat.mode;
               req_address      <= next_beat.address;
               req_mem_data     <= next_beat.mem_data;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_retires.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected, status %h", $time, rsp_status);
            end else begin
               retire_exp = predicted_retires.pop_front();
               check_field("status", retire_exp.status, rsp_status);
               check_field("mem_write", retire_exp.mem_write, rsp_mem_write);
               check_field("write_data", retire_exp.write_data, rsp_write_data);
               check_field("jump_taken", retire_exp.jump_taken, rsp_jump_taken);
               check_field("jump_target", retire_exp.jump_target, rsp_jump_target);
               check_field("acc_a_value", retire_exp.next_state.acc_a, rsp_acc_a_value);
               check_field("acc_b_value", retire_exp.next_state.acc_b, rsp_acc_b_value);
               check_field("index_value", retire_exp.next_state.index, rsp_index_value);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_window() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      op_type                op;
      logic                  sel;
      logic [OPC_WIDTH-1:0]  opc;
      logic [MODE_WIDTH-1:0] mode;
      logic [ADDR_WIDTH-1:0] addr;
      logic [WORD_WIDTH-1:0] mem;

      // Directed: sign extension, wraparound, every operation, taken and untaken
      // branches, halt, illegal mode and undefined opcodes.
      queue_instr({OP_LI, SEL_A}, MODE_DIRECT, 12'hFFF, 20'h00000);
      queue_instr({OP_LI, SEL_B}, MODE_DIRECT, 12'h7FF, 20'hFFFFF);
      queue_instr({OP_ADD, SEL_A}, 2'd1, 12'h000, 20'h00001);
      queue_instr({OP_TZ, SEL_A}, 2'd2, 12'hABC, 20'h00000);
      queue_instr({OP_SUB, SEL_B}, 2'd3, 12'h001, 20'hFFFFF);
      queue_instr({OP_TP, SEL_B}, 2'd0, 12'hFFF, 20'h00000);
      queue_instr({OP_COM, SEL_A}, 2'd1, 12'h123, 20'h55555);
      queue_instr({OP_TN, SEL_A}, 2'd0, 12'h000, 20'hFFFFF);
      queue_instr({OP_TP, SEL_A}, 2'd0, 12'h321, 20'h00000);
      queue_instr({OP_LD, SEL_A}, 2'd2, 12'h800, 20'h80000);
      queue_instr({OP_ST, SEL_A}, 2'd3, 12'hFFF, 20'h7FFFF);
      queue_instr({OP_EM, SEL_B}, 2'd0, 12'h010, 20'h12345);
      queue_instr({OP_AND, SEL_B}, 2'd1, 12'h020, 20'h0F0F0);
      queue_instr({OP_OR, SEL_A}, 2'd2, 12'h030, 20'h0000F);
      queue_instr({OP_XOR, SEL_B}, 2'd3, 12'h040, 20'hFFFFF);
      queue_instr({OP_CLR, SEL_B}, 2'd0, 12'h050, 20'hFFFFF);
      queue_instr({OP_LDXR, SEL_A}, 2'd1, 12'h060, 20'hFFABC);
      queue_instr({OP_STXR, SEL_A}, 2'd2, 12'h070, 20'h00000);
      queue_instr({OP_LIXR, SEL_A}, 2'd3, 12'h555, 20'h00000);
      queue_instr({OP_TR, SEL_A}, 2'd0, 12'hAAA, 20'h00000);
      queue_instr({OP_NOP, SEL_A}, 2'd1, 12'h000, 20'h00000);
      queue_instr({OP_HALT, SEL_A}, 2'd0, 12'h000, 20'h00000);
      queue_instr({OP_LI, SEL_A}, 2'd3, 12'h7FF, 20'h00000);
      queue_instr({OP_HALT, SEL_B}, 2'd0, 12'h000, 20'h00000);
      queue_instr({OP_NOP, SEL_B}, 2'd0, 12'h000, 20'h00000);
      queue_instr({OP_LDXR, SEL_B}, 2'd0, 12'h000, 20'hFFFFF);
      queue_instr({OP_LIXR, SEL_B}, 2'd0, 12'hFFF, 20'h00000);
      queue_instr({OP_STXR, SEL_B}, 2'd0, 12'h000, 20'h00000);
      queue_instr({OP_TR, SEL_B}, 2'd0, 12'hFFF, 20'h00000);
      queue_instr({OP_UNLISTED, SEL_B}, 2'd0, 12'hFFF, 20'hFFFFF);

      // Collect every defined operation for the random part.
      op = op.first();
      do begin
         legal_ops.push_back(op);
         op = op.next();
      end while (op != op.first());

      // Random: mostly defined operations with random operands, some raw opcodes.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 15) == 0) begin
            opc = OPC_WIDTH'($urandom());
         end else begin
            op  = legal_ops[$urandom_range(0, legal_ops.size() - 1)];
            sel = 1'($urandom_range(0, 1));
            // Operations without a B form get the A select most of the time.
            if ((op == OP_HALT || op == OP_NOP || op == OP_LDXR || op == OP_LIXR ||
                 op == OP_STXR || op == OP_TR) && $urandom_range(0, 7) != 0)
               sel = SEL_A;
            opc = {op, sel};
         end
         mode = MODE_WIDTH'($urandom_range(0, 3));
         if (opc[OPC_WIDTH-1:1] == OP_LI && $urandom_range(0, 5) != 0) mode = MODE_DIRECT;
         case ($urandom_range(0, 7))
            0: addr = '0;
            1: addr = '1;
            2: addr = {1'b1, {(ADDR_WIDTH-1){1'b0}}};
            default: addr = ADDR_WIDTH'($urandom());
         endcase
         case ($urandom_range(0, 7))
            0: mem = '0;
            1: mem = '1;
            2: mem = {1'b1, {(WORD_WIDTH-1){1'b0}}};
            3: mem = WORD_WIDTH'(1);
            default: mem = WORD_WIDTH'($urandom());
         endcase
         queue_instr(opc, mode, addr, mem);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every result to come back.
      while (instr_queue.size() != 0 || req_valid) @(posedge clock);
      while (predicted_retires.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== accumulator_cpu_execute_stage_top.f =====
src/acpu_pkg.sv
src/acpu_exec.sv
src/acpu_regfile.sv
src/accumulator_cpu_execute_stage_top.sv
tb/sv/accumulator_cpu_execute_stage_top_tb.sv
